FILE: sv/pirr_pkg.sv
// ----------------------------------------------------------------------------
// pirr_pkg: shared constants, types and helpers for the rotated-rectangle
// hit test (register indexes, datapath widths, split-multiply helpers)
// ----------------------------------------------------------------------------
package pirr_pkg;

	// register map
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 32;
	localparam logic [CfgIdxW-1:0] REG_ORIGIN_X     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_BOX_WIDTH    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_BOX_HEIGHT   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SCALE_FACTOR = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_ROT_COS      = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_ROT_SIN      = 3'd6;

	// field widths
	localparam int CoordW = 32;
	localparam int SizeW  = 12;
	localparam int ScaleW = 16;
	localparam int TrigW  = 16;
	localparam int FracShift = 7;   // Q24.8 to Q.15

	localparam logic [ScaleW-1:0] ScaleReset = 16'd256;
	localparam logic [TrigW-1:0]  CosReset   = 16'd32767;

	localparam int NumCorners = 4;

	// datapath widths
	localparam int ExtW   = 20;                 // scaled extent, whole pixels
	localparam int ProdW  = 36;                 // extent times cos or sin
	localparam int DeltaW = ProdW + 1;          // corner offset or edge delta
	localparam int PosW   = CoordW + 1 + FracShift;  // point minus origin, Q.15
	localparam int RelW   = PosW + 1;           // point minus corner
	localparam int SplitW = 20;                 // low half of a split operand
	localparam int RelHiW   = RelW - SplitW;
	localparam int DeltaHiW = DeltaW - SplitW;
	localparam int HhW = RelHiW + DeltaHiW;
	localparam int HlW = RelHiW + SplitW + 1;
	localparam int LhW = SplitW + 1 + DeltaHiW;
	localparam int LlW = 2 * SplitW;
	localparam int CrossW = RelW + DeltaW;

	// rectangle geometry derived from the registers
	typedef struct packed {
		logic signed [CoordW-1:0] origin_x;
		logic signed [CoordW-1:0] origin_y;
		logic signed [ProdW-1:0]  ew_cos;
		logic signed [ProdW-1:0]  ew_sin;
		logic signed [ProdW-1:0]  eh_cos;
		logic signed [ProdW-1:0]  eh_sin;
	} geom_t;

	// partial products of one cross term
	typedef struct packed {
		logic signed [HhW-1:0] hh;
		logic signed [HlW-1:0] hl;
		logic signed [LhW-1:0] lh;
		logic [LlW-1:0]        ll;
	} part_t;

	function automatic logic signed [DeltaW-1:0] ext_prod(input logic signed [ProdW-1:0] p);
		return $signed({{(DeltaW-ProdW){p[ProdW-1]}}, p});
	endfunction

	// rel * dlt as four narrow products
	function automatic part_t part_mul(input logic signed [RelW-1:0] rel,
			input logic signed [DeltaW-1:0] dlt);
		part_t p;
		logic signed [RelHiW-1:0]   rh;
		logic [SplitW-1:0]          rl;
		logic signed [DeltaHiW-1:0] dh;
		logic [SplitW-1:0]          dl;
		rh = $signed(rel[RelW-1:SplitW]);
		rl = rel[SplitW-1:0];
		dh = $signed(dlt[DeltaW-1:SplitW]);
		dl = dlt[SplitW-1:0];
		p.hh = rh * dh;
		p.hl = rh * $signed({1'b0, dl});
		p.lh = $signed({1'b0, rl}) * dh;
		p.ll = rl * dl;
		return p;
	endfunction

	// recombine the partial products
	function automatic logic signed [CrossW-1:0] part_sum(input part_t p);
		logic signed [CrossW-1:0] a;
		logic signed [CrossW-1:0] b;
		logic signed [CrossW-1:0] c;
		logic signed [CrossW-1:0] d;
		a = $signed({p.hh, {(2*SplitW){1'b0}}});
		b = $signed({{(CrossW-HlW-SplitW){p.hl[HlW-1]}}, p.hl, {SplitW{1'b0}}});
		c = $signed({{(CrossW-LhW-SplitW){p.lh[LhW-1]}}, p.lh, {SplitW{1'b0}}});
		d = $signed({{(CrossW-LlW){1'b0}}, p.ll});
		return a + b + c + d;
	endfunction

endpackage

FILE: sv/pirr_cfg.sv
// ----------------------------------------------------------------------------
// pirr_cfg: configuration registers and rectangle geometry
// Holds the seven registers and derives the scaled extents and their
// rotated components in a two-stage free-running chain.
// ----------------------------------------------------------------------------
module pirr_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [pirr_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [pirr_pkg::CfgDataW-1:0]   cfg_data,
	output pirr_pkg::geom_t                 geom
);
	import pirr_pkg::*;

	logic signed [CoordW-1:0] origin_x_q;
	logic signed [CoordW-1:0] origin_y_q;
	logic [SizeW-1:0]         box_width_q;
	logic [SizeW-1:0]         box_height_q;
	logic [ScaleW-1:0]        scale_factor_q;
	logic signed [TrigW-1:0]  rot_cos_q;
	logic signed [TrigW-1:0]  rot_sin_q;

	logic [SizeW+ScaleW-1:0] ew_full;
	logic [SizeW+ScaleW-1:0] eh_full;
	logic [ExtW-1:0]         ew_q;
	logic [ExtW-1:0]         eh_q;
	logic signed [ProdW-1:0] ew_cos_q;
	logic signed [ProdW-1:0] ew_sin_q;
	logic signed [ProdW-1:0] eh_cos_q;
	logic signed [ProdW-1:0] eh_sin_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			box_width_q    <= '0;
			box_height_q   <= '0;
			scale_factor_q <= ScaleReset;
			rot_cos_q      <= CosReset;
			rot_sin_q      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ORIGIN_X:     origin_x_q     <= cfg_data[CoordW-1:0];
				REG_ORIGIN_Y:     origin_y_q     <= cfg_data[CoordW-1:0];
				REG_BOX_WIDTH:    box_width_q    <= cfg_data[SizeW-1:0];
				REG_BOX_HEIGHT:   box_height_q   <= cfg_data[SizeW-1:0];
				REG_SCALE_FACTOR: scale_factor_q <= cfg_data[ScaleW-1:0];
				REG_ROT_COS:      rot_cos_q      <= cfg_data[TrigW-1:0];
				REG_ROT_SIN:      rot_sin_q      <= cfg_data[TrigW-1:0];
				default: ;
			endcase
		end
	end

	// scaled extents, truncated to whole pixels
	assign ew_full = box_width_q * scale_factor_q;
	assign eh_full = box_height_q * scale_factor_q;

	always_ff @(posedge clk) begin
		ew_q <= ew_full[SizeW+ScaleW-1:8];
		eh_q <= eh_full[SizeW+ScaleW-1:8];
	end

	// rotated extent components in Q.15 pixels
	always_ff @(posedge clk) begin
		ew_cos_q <= $signed({1'b0, ew_q}) * rot_cos_q;
		ew_sin_q <= $signed({1'b0, ew_q}) * rot_sin_q;
		eh_cos_q <= $signed({1'b0, eh_q}) * rot_cos_q;
		eh_sin_q <= $signed({1'b0, eh_q}) * rot_sin_q;
	end

	assign geom.origin_x = origin_x_q;
	assign geom.origin_y = origin_y_q;
	assign geom.ew_cos   = ew_cos_q;
	assign geom.ew_sin   = ew_sin_q;
	assign geom.eh_cos   = eh_cos_q;
	assign geom.eh_sin   = eh_sin_q;

endmodule

FILE: sv/point_in_rotated_rect_test.sv
// throughput: one point per cycle; each stage stalls only when its successor is full
// critical stages: the split cross multiply and the 78-bit cross compare
// reset: arst_n clears all stage valid bits and loads the register reset values
// origin follows a write directly; extents pass a free-running register chain
// the input is held off in any cycle that offers a register write
// ----------------------------------------------------------------------------
// point_in_rotated_rect_test: crossing-number hit test of a point against a
// scaled, rotated rectangle with an exact cross-multiplied edge test
// ----------------------------------------------------------------------------
module point_in_rotated_rect_test (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [63:0]                    s_tdata,   // point_x [31:0], point_y [63:32]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // inside_res [0], zero [7:1]
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pirr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [pirr_pkg::CfgDataW-1:0]  cfg_data
);
	import pirr_pkg::*;

	geom_t geom;

	// stage valids and enables
	logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
	logic en1, en2, en3, en4, en5, en6;

	logic signed [CoordW-1:0] pt_x_s1;
	logic signed [CoordW-1:0] pt_y_s1;
	logic signed [CoordW:0]   dx_org;
	logic signed [CoordW:0]   dy_org;
	logic signed [PosW-1:0]   px_s2;
	logic signed [PosW-1:0]   py_s2;

	logic signed [DeltaW-1:0] off_x [NumCorners];
	logic signed [DeltaW-1:0] off_y [NumCorners];
	logic signed [DeltaW-1:0] edge_dx [NumCorners];
	logic signed [DeltaW-1:0] edge_dy [NumCorners];

	logic signed [RelW-1:0] rx_s3 [NumCorners];
	logic signed [RelW-1:0] ry_s3 [NumCorners];
	logic [NumCorners-1:0]  cross_s3;
	part_t                  lpart_s4 [NumCorners];
	part_t                  rpart_s4 [NumCorners];
	logic [NumCorners-1:0]  cross_s4;
	logic signed [CrossW-1:0] lhs_s5 [NumCorners];
	logic signed [CrossW-1:0] rhs_s5 [NumCorners];
	logic [NumCorners-1:0]  cross_s5;
	logic [NumCorners-1:0]  hit;
	logic                   inside_s6;

	pirr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	assign cfg_ready = 1'b1;

	// backpressure chain, a stage moves when empty or its successor moves
	assign en6 = !v6_q || m_tready;
	assign en5 = !v5_q || en6;
	assign en4 = !v4_q || en5;
	assign en3 = !v3_q || en4;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;
	// no new word while a register write is offered
	assign s_tready = en1 && !cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			v6_q <= 1'b0;
		end else begin
			if (en1) v1_q <= s_tvalid && !cfg_valid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (en4) v4_q <= v3_q;
			if (en5) v5_q <= v4_q;
			if (en6) v6_q <= v5_q;
		end
	end

	// stage 1: capture the input word
	always_ff @(posedge clk) begin
		if (en1) begin
			pt_x_s1 <= s_tdata[CoordW-1:0];
			pt_y_s1 <= s_tdata[2*CoordW-1:CoordW];
		end
	end

	// stage 2: point relative to the origin corner, in Q.15
	assign dx_org = $signed({pt_x_s1[CoordW-1], pt_x_s1})
		- $signed({geom.origin_x[CoordW-1], geom.origin_x});
	assign dy_org = $signed({pt_y_s1[CoordW-1], pt_y_s1})
		- $signed({geom.origin_y[CoordW-1], geom.origin_y});

	always_ff @(posedge clk) begin
		if (en2) begin
			px_s2 <= {dx_org, {FracShift{1'b0}}};
			py_s2 <= {dy_org, {FracShift{1'b0}}};
		end
	end

	// corner offsets and edge deltas, each edge runs from corner i to i-1
	always_comb begin
		off_x[0] = '0;
		off_y[0] = '0;
		off_x[1] = ext_prod(geom.ew_cos);
		off_y[1] = ext_prod(geom.ew_sin);
		off_x[2] = ext_prod(geom.ew_cos) - ext_prod(geom.eh_sin);
		off_y[2] = ext_prod(geom.ew_sin) + ext_prod(geom.eh_cos);
		off_x[3] = -ext_prod(geom.eh_sin);
		off_y[3] = ext_prod(geom.eh_cos);
		edge_dx[0] = -ext_prod(geom.eh_sin);
		edge_dy[0] = ext_prod(geom.eh_cos);
		edge_dx[1] = -ext_prod(geom.ew_cos);
		edge_dy[1] = -ext_prod(geom.ew_sin);
		edge_dx[2] = ext_prod(geom.eh_sin);
		edge_dy[2] = -ext_prod(geom.eh_cos);
		edge_dx[3] = ext_prod(geom.ew_cos);
		edge_dy[3] = ext_prod(geom.ew_sin);
	end

	for (genvar e = 0; e < NumCorners; e++) begin : g_edge
		localparam int Prev = (e + NumCorners - 1) % NumCorners;
		logic dy_pos;

		// stage 3: point relative to this corner
		always_ff @(posedge clk) begin
			if (en3) begin
				rx_s3[e] <= $signed({px_s2[PosW-1], px_s2})
					- $signed({{(RelW-DeltaW){off_x[e][DeltaW-1]}}, off_x[e]});
				ry_s3[e] <= $signed({py_s2[PosW-1], py_s2})
					- $signed({{(RelW-DeltaW){off_y[e][DeltaW-1]}}, off_y[e]});
			end
		end

		// edge straddles the point row when exactly one end lies above it
		assign cross_s3[e] = ry_s3[e][RelW-1] ^ ry_s3[Prev][RelW-1];

		// stage 4: partial products of both cross terms
		always_ff @(posedge clk) begin
			if (en4) begin
				lpart_s4[e] <= part_mul(rx_s3[e], edge_dy[e]);
				rpart_s4[e] <= part_mul(ry_s3[e], edge_dx[e]);
				cross_s4[e] <= cross_s3[e];
			end
		end

		// stage 5: full cross terms
		always_ff @(posedge clk) begin
			if (en5) begin
				lhs_s5[e]   <= part_sum(lpart_s4[e]);
				rhs_s5[e]   <= part_sum(rpart_s4[e]);
				cross_s5[e] <= cross_s4[e];
			end
		end

		// strict left-of test, direction set by the sign of the edge delta
		assign dy_pos = !edge_dy[e][DeltaW-1] && (edge_dy[e] != '0);
		assign hit[e] = cross_s5[e] &&
			(dy_pos ? (lhs_s5[e] < rhs_s5[e]) : (rhs_s5[e] < lhs_s5[e]));
	end

	// stage 6: even-odd parity of the crossings
	always_ff @(posedge clk) begin
		if (en6) begin
			inside_s6 <= ^hit;
		end
	end

	assign m_tvalid = v6_q;
	assign m_tdata  = {7'b0, inside_s6};

endmodule

FILE: sv/pirr_chk.sv
// ----------------------------------------------------------------------------
// pirr_chk: port-level checks for the rotated-rectangle hit test
// Watches the stream and configuration ports over time.
// ----------------------------------------------------------------------------
module pirr_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [7:0]                     m_tdata,
	input logic                           cfg_valid,
	input logic                           cfg_ready
);

	// a ready sink downstream frees the whole pipeline unless a register write is offered
	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready && !cfg_valid |-> s_tready)
		else $error("input not ready while output sink is ready");

	// a stalled result word stays and holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed or dropped");

	// padding bits of the result word are zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:1] == 7'b0)
		else $error("result padding bits not zero");

	// register writes are never back-pressured
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

	// no result word right out of reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result word valid right after reset");

endmodule

bind point_in_rotated_rect_test pirr_chk u_pirr_chk (.*);
